// ===== src/dlpd_pkg.sv =====
// Package with the parse phases, character codes and scaling constants of the line parser.
package dlpd_pkg;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_NUMBER = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned FscWidth   = 9;
  localparam int unsigned ValueWidth = 16;
  localparam logic [FscWidth-1:0] FscReset = 9'd200;

  // Division by 100 of a 16-bit product: ((p >> 2) * 5243) >> 17 is exact for every 16-bit p.
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int unsigned RecipShift   = 17;
  localparam int unsigned RecipProdW   = ValueWidth - 2 + 13;

  localparam logic [2:0] REG_FULL_SCALE = 3'd0;

endpackage

// ===== src/decimal_line_to_pwm_duty.sv =====
// Top level: decimal line parser that turns a received value into a PWM compare count.
//
// Received bytes are parsed line by line like atoi: leading blanks are skipped, one optional
// sign is taken, decimal digits accumulate modulo 65536, and the first non-digit ends the
// number. A CR or LF reports the signed 16-bit line value; a positive value has its low
// 8 bits taken as a percent of full_scale_count (truncated), and a count that is in range and
// differs from the last one is applied. One byte is accepted every clock cycle unless out_ready
// holds the output, and every byte gives one result word; the percent multiply and the divide-by-100
// reciprocal multiply sit on either side of the s1 pipeline register. The APB register
// full_scale_count lies at byte address 0 and may only be written while the block is idle.
module decimal_line_to_pwm_duty
  import dlpd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         line_end_o,
  output logic signed [ValueWidth-1:0] line_value_o,
  output logic                         duty_update_o,
  output logic [FscWidth-1:0]          duty_count_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // Configuration register.
  logic [FscWidth-1:0] fsc_q;
  logic                cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = ({paddr[2], 2'b00} == REG_FULL_SCALE);
  assign prdata  = cfg_hit ? {{(32-FscWidth){1'b0}}, fsc_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsc_q <= FscReset;
    end else if (psel && penable && pwrite && cfg_hit) begin
      fsc_q <= pwdata[FscWidth-1:0];
    end
  end

  // Handshake and pipeline control.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_load;
  logic in_accept;

  assign out_load    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || out_load;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Parse state.
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic                  neg_q, neg_d;
  phase_e                phase_q, phase_d;

  logic                  is_eol;
  logic                  is_blank;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [ValueWidth-1:0] acc_times_ten;
  logic [ValueWidth-1:0] line_val;

  assign is_eol   = (rx_byte_i == CH_CR) || (rx_byte_i == CH_LF);
  assign is_blank = (rx_byte_i == CH_SPACE) || (rx_byte_i == CH_TAB) ||
                    (rx_byte_i == CH_VT) || (rx_byte_i == CH_FF);
  assign is_digit = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);
  assign digit    = 4'(rx_byte_i - CH_ZERO);
  assign acc_times_ten = (acc_q << 3) + (acc_q << 1);
  assign line_val = neg_q ? (ValueWidth'(0) - acc_q) : acc_q;

  always_comb begin
    acc_d   = acc_q;
    neg_d   = neg_q;
    phase_d = phase_q;
    if (is_eol) begin
      acc_d   = '0;
      neg_d   = 1'b0;
      phase_d = PH_SKIP;
    end else begin
      case (phase_q)
        PH_SKIP: begin
          if (is_blank) begin
            phase_d = PH_SKIP;
          end else if (rx_byte_i == CH_PLUS) begin
            phase_d = PH_NUMBER;
          end else if (rx_byte_i == CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_NUMBER;
          end else if (is_digit) begin
            acc_d   = {{(ValueWidth-4){1'b0}}, digit};
            phase_d = PH_NUMBER;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_NUMBER: begin
          if (is_digit) begin
            acc_d = acc_times_ten + {{(ValueWidth-4){1'b0}}, digit};
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      neg_q   <= 1'b0;
      phase_q <= PH_SKIP;
    end else if (in_accept) begin
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      phase_q <= phase_d;
    end
  end

  // First stage: line value and percent product.
  logic                  s1_eol_q;
  logic                  s1_pos_q;
  logic [ValueWidth-1:0] s1_value_q;
  logic [ValueWidth-1:0] s1_prod_q;
  logic [ValueWidth:0]   pct_prod;

  assign pct_prod = line_val[7:0] * fsc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_eol_q   <= is_eol;
      s1_pos_q   <= is_eol && (line_val != '0) && !line_val[ValueWidth-1];
      s1_value_q <= is_eol ? line_val : '0;
      s1_prod_q  <= pct_prod[ValueWidth-1:0];
    end
  end

  // Second stage: divide by 100, range and change check, compare register.
  logic [RecipProdW-1:0] recip_prod;
  logic [FscWidth:0]     count;
  logic                  apply;
  logic [FscWidth-1:0]   last_q;

  // The product is divided by 4 first so that the reciprocal by 25 stays exact.
  assign recip_prod = s1_prod_q[ValueWidth-1:2] * RecipHundred;
  assign count      = recip_prod[RecipProdW-1:RecipShift];
  assign apply      = s1_pos_q && (count != {1'b0, last_q}) && (count <= {1'b0, fsc_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q && apply) begin
        last_q <= count[FscWidth-1:0];
      end
    end
  end

  logic                  o_eol_q;
  logic [ValueWidth-1:0] o_value_q;
  logic                  o_update_q;
  logic [FscWidth-1:0]   o_count_q;

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      o_eol_q    <= s1_eol_q;
      o_value_q  <= s1_value_q;
      o_update_q <= apply;
      o_count_q  <= apply ? count[FscWidth-1:0] : last_q;
    end
  end

  assign line_end_o    = o_eol_q;
  assign line_value_o  = o_value_q;
  assign duty_update_o = o_update_q;
  assign duty_count_o  = o_count_q;

endmodule

// ===== tb/sv/decimal_line_to_pwm_duty_tb.sv =====
// Testbench for the decimal line parser that drives the PWM compare count.
`timescale 1ns / 100ps

module decimal_line_to_pwm_duty_tb;
  import dlpd_pkg::*;

  localparam logic [2:0] ADDR_FULL_SCALE = 3'(REG_FULL_SCALE << 2);
  localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;
  localparam int unsigned RAND_PHASE_BYTES = 280;

  typedef struct packed {
    logic                         line_end;
    logic signed [ValueWidth-1:0] line_value;
    logic                         duty_update;
    logic [FscWidth-1:0]          duty_count;
  } duty_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   rx_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         line_end;
  logic signed [ValueWidth-1:0] line_value;
  logic                         duty_update;
  logic [FscWidth-1:0]          duty_count;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [2:0]                   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // Shadow of the parser and of the PWM register.
  logic [FscWidth-1:0]   full_scale_q;
  logic [ValueWidth-1:0] acc_q;
  logic                  neg_q;
  phase_e                phase_q;
  logic [FscWidth-1:0]   applied_count_q;

  duty_word_t pending_words[$];
  int         mismatch_count = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  bit         steady_send = 1'b0;
  int         hold_cycles = 0;

  decimal_line_to_pwm_duty u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .line_end_o   (line_end),
    .line_value_o (line_value),
    .duty_update_o(duty_update),
    .duty_count_o (duty_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("decimal_line_to_pwm_duty_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic clear_parser();
    acc_q   = '0;
    neg_q   = 1'b0;
    phase_q = PH_SKIP;
  endtask

  // Next result word for one byte; updates the shadow parser.
  function automatic duty_word_t parse_to_duty(input logic [7:0] c);
    duty_word_t            w;
    logic [ValueWidth-1:0] v;
    logic [15:0]           product;
    logic [15:0]           count;
    logic                  is_digit;
    w        = '0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_CR || c == CH_LF) begin
      v = neg_q ? (16'd0 - acc_q) : acc_q;
      w.line_end   = 1'b1;
      w.line_value = v;
      if (v != '0 && !v[ValueWidth-1]) begin
        product = 16'({8'd0, v[7:0]} * {7'd0, full_scale_q});
        count   = product / 16'd100;
        if (count != {7'd0, applied_count_q} && count <= {7'd0, full_scale_q}) begin
          applied_count_q = count[FscWidth-1:0];
          w.duty_update   = 1'b1;
        end
      end
      acc_q   = '0;
      neg_q   = 1'b0;
      phase_q = PH_SKIP;
    end else begin
      case (phase_q)
        PH_SKIP: begin
          if (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF}) begin
            phase_q = PH_SKIP;
          end else if (c == CH_PLUS) begin
            phase_q = PH_NUMBER;
          end else if (c == CH_MINUS) begin
            neg_q   = 1'b1;
            phase_q = PH_NUMBER;
          end else if (is_digit) begin
            acc_q   = {8'd0, c - CH_ZERO};
            phase_q = PH_NUMBER;
          end else begin
            phase_q = PH_DONE;
          end
        end
        PH_NUMBER: begin
          if (is_digit) begin
            acc_q = 16'(acc_q * 16'd10 + {8'd0, c - CH_ZERO});
          end else begin
            phase_q = PH_DONE;
          end
        end
        default: phase_q = PH_DONE;
      endcase
    end
    w.duty_count = applied_count_q;
    return w;
  endfunction

  // Offers one byte and waits for its handshake. Entered and left at a rising edge.
  task automatic send_byte(input logic [7:0] b);
    bit taken;
    if (!steady_send && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready;
      @(posedge clk);
    end while (!taken);
    pending_words.push_back(parse_to_duty(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line_end();
    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  // Mostly well-formed numbers with random decoration, plus noise and broken lines.
  task automatic send_random_line();
    logic [7:0] blanks[4];
    logic [7:0] junk;
    int         kind;
    int         ndig;
    int         r;
    blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    kind   = $urandom_range(0, 9);
    if (kind <= 5) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(blanks[$urandom_range(0, 3)]);
      end
      r = $urandom_range(0, 5);
      if (r == 0) send_byte(CH_MINUS);
      else if (r == 1) send_byte(CH_PLUS);
      ndig = (kind == 5) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      repeat (ndig) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do junk = 8'($urandom_range(0, 255)); while (junk == CH_CR || junk == CH_LF);
          send_byte(junk);
        end
      end
    end else if (kind <= 7) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      r = $urandom_range(0, 2);
      if (r == 1) send_byte(CH_PLUS);
      else if (r == 2) send_byte(CH_MINUS);
    end else begin
      repeat ($urandom_range(8, 14)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    send_line_end();
  endtask

  task automatic send_random_lines(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_line();
  endtask

  // Stops the input and waits until every word has come out and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((addr >> 2) == REG_FULL_SCALE) full_scale_q = data[FscWidth-1:0];
  endtask

  task automatic check_full_scale_readback();
    logic [31:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_FULL_SCALE;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[FscWidth-1:0] !== full_scale_q) begin
      report_mismatch("full_scale_count readback", int'(got[FscWidth-1:0]), int'(full_scale_q));
    end
  endtask

  task automatic set_full_scale(input int value);
    drain();
    apb_write(ADDR_FULL_SCALE, 32'(value));
    check_full_scale_readback();
  endtask

  // Output side: random stall patterns, plus a long hold-off on request.
  initial begin
    duty_word_t want;
    int         mode;
    int         mode_left;
    bit         nxt;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("word with nothing pending, line_end", int'(line_end), 0);
        end else begin
          want = pending_words.pop_front();
          if (line_end !== want.line_end)
            report_mismatch("line_end", int'(line_end), int'(want.line_end));
          if (line_value !== want.line_value)
            report_mismatch("line_value", int'($signed(line_value)), int'(want.line_value));
          if (duty_update !== want.duty_update)
            report_mismatch("duty_update", int'(duty_update), int'(want.duty_update));
          if (duty_count !== want.duty_count)
            report_mismatch("duty_count", int'(duty_count), int'(want.duty_count));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        nxt = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        case (mode)
          0:       nxt = 1'b1;
          1:       nxt = $urandom_range(0, 1);
          2:       nxt = ($urandom_range(0, 7) != 0);
          default: nxt = ($urandom_range(0, 3) == 0);
        endcase
      end
      @(posedge clk);
      out_ready <= nxt;
    end
  end

  task automatic test_reset_readback();
    check_full_scale_readback();
  endtask

  task automatic test_directed();
    send_text("100");
    send_byte(CH_LF);
    send_byte(CH_TAB);
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_byte(CH_SPACE);
    send_text("-7");
    send_byte(CH_CR);
    // A sign with no digits reads as zero.
    send_byte(CH_PLUS);
    send_byte(CH_LF);
    send_byte(8'h00);
    send_byte(CH_LF);
    // The top byte value ends the number; 255 percent scales above full scale.
    send_text("255");
    send_byte(8'hFF);
    send_text("9");
    send_byte(CH_LF);
    // Wraps past 65535 and reads as a negative value.
    send_text("99999");
    send_byte(CH_CR);
  endtask

  task automatic test_full_scale_extremes();
    set_full_scale(1);
    send_random_lines(150);
    set_full_scale(257);
    send_random_lines(150);
  endtask

  task automatic test_unmapped_write();
    drain();
    apb_write(ADDR_UNMAPPED, $urandom());
    check_full_scale_readback();
    send_random_lines(80);
  endtask

  task automatic test_random_lines();
    set_full_scale(100);
    send_random_lines(RAND_PHASE_BYTES);
    for (int i = 0; i < 3; i++) begin
      set_full_scale($urandom_range(1, 257));
      send_random_lines(RAND_PHASE_BYTES);
    end
  endtask

  task automatic test_backpressure();
    set_full_scale(200);
    steady_send = 1'b1;
    hold_cycles = 400;
    send_random_lines(250);
    steady_send = 1'b0;
  endtask

  initial begin
    full_scale_q    = FscReset;
    applied_count_q = '0;
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_readback();
    test_directed();
    test_full_scale_extremes();
    test_unmapped_write();
    test_random_lines();
    test_backpressure();
    drain();

    if (mismatch_count == 0) begin
      $display("decimal_line_to_pwm_duty_tb: PASS");
    end else begin
      $display("decimal_line_to_pwm_duty_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== decimal_line_to_pwm_duty.f =====
src/dlpd_pkg.sv
src/decimal_line_to_pwm_duty.sv
tb/sv/decimal_line_to_pwm_duty_tb.sv
